FILE: hdl/pls_pkg.sv
package pls_pkg;

  // Line geometry
  localparam int LineIn       = 384;
  localparam int LineOut      = 240;
  localparam int ActiveW      = 320;
  localparam int ActiveStart  = 32;
  localparam int CropStart    = 72;
  localparam int InnerW       = 225;
  localparam int LeftBar      = 7;
  localparam int RightBarStart = 232;

  localparam int SrcColW = 9;
  localparam int OutColW = 8;
  localparam int ColorW  = 16;
  localparam int CodeW   = 8;
  localparam int RunCntW = 3;

  localparam logic [ColorW-1:0] Black = '0;

  // Palette storage
  localparam int PaletteDepth = 256;
  localparam int PalAddrW     = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;

  localparam logic [SrcColW-1:0] LastSrcCol  = SrcColW'(LineIn - 1);
  localparam logic [OutColW:0]   LineOutW    = (OutColW + 1)'(LineOut);
  localparam logic [SrcColW-1:0] NoMatchCol  = '1;

  typedef enum logic [1:0] {
    ModeStretch = 2'd0,
    ModeCrop    = 2'd1,
    ModePillar  = 2'd2,
    ModeCover   = 2'd3
  } display_mode_e;

  typedef enum logic {
    OpPixel    = 1'b0,
    OpPalWrite = 1'b1
  } op_e;

  typedef logic [SrcColW-1:0] col_map_t [1 << OutColW];

  // Source column for each output column, stretch and cover
  function automatic col_map_t build_stretch_map();
    col_map_t m;
    for (int i = 0; i < (1 << OutColW); i++) begin
      if (i < LineOut) begin
        m[i] = SrcColW'(ActiveStart + (i * 4 + 1) / 3);
      end else begin
        m[i] = NoMatchCol;
      end
    end
    return m;
  endfunction

  // Source column for each output column, pillarbox (bars included)
  function automatic col_map_t build_pillar_map();
    col_map_t m;
    int s;
    for (int i = 0; i < (1 << OutColW); i++) begin
      if (i < LeftBar) begin
        m[i] = '0;
      end else if (i < RightBarStart) begin
        s = ((i - LeftBar) * ActiveW + InnerW / 2) / InnerW;
        if (s > ActiveW - 1) begin
          s = ActiveW - 1;
        end
        m[i] = SrcColW'(ActiveStart + s);
      end else if (i < LineOut) begin
        m[i] = LastSrcCol;
      end else begin
        m[i] = NoMatchCol;
      end
    end
    return m;
  endfunction

  localparam col_map_t StretchMap = build_stretch_map();
  localparam col_map_t PillarMap  = build_pillar_map();

  // Source column that feeds output column x under the given mode
  function automatic logic [SrcColW-1:0] map_column(display_mode_e mode,
                                                     logic [OutColW-1:0] x);
    logic [SrcColW-1:0] col;
    unique case (mode)
      ModeCrop:   col = SrcColW'(CropStart) + SrcColW'(x);
      ModePillar: col = PillarMap[x];
      default:    col = StretchMap[x];
    endcase
    return col;
  endfunction

  // Black bar pixel in pillarbox mode
  function automatic logic is_bar(display_mode_e mode, logic [OutColW-1:0] x);
    return (mode == ModePillar) &&
           ((x < OutColW'(LeftBar)) || (x >= OutColW'(RightBarStart)));
  endfunction

endpackage

FILE: hdl/pls_req_if.sv
interface pls_req_if;
  import pls_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [CodeW-1:0]    pixel_code;
  logic [CodeW-1:0]    palette_index;
  logic [ColorW-1:0]   palette_color;

  modport source (output valid, op, pixel_code, palette_index, palette_color,
                  input ready);
  modport sink   (input valid, op, pixel_code, palette_index, palette_color,
                  output ready);
endinterface

FILE: hdl/pls_rsp_if.sv
interface pls_rsp_if;
  import pls_pkg::*;

  logic                valid;
  logic                ready;
  logic [OutColW-1:0]  out_column;
  logic [ColorW-1:0]   pixel_color;
  logic                last_of_run;

  modport source (output valid, out_column, pixel_color, last_of_run,
                  input ready);
  modport sink   (input valid, out_column, pixel_color, last_of_run,
                  output ready);
endinterface

FILE: hdl/palette_line_scaler_unit.sv
// Nearest-neighbor horizontal scaler: takes a 384-pixel source line of 8-bit
// palette codes, left to right, one request per cycle, and emits the 240-pixel
// RGB565 output line in column order. A palette write request stores one
// color and yields nothing; palette entries must be loaded before use. A
// source pixel request yields the output pixels mapped to its column: none or
// one in the active area, seven at the first column and eight at the last in
// pillarbox mode. The palette is a 256 x 16 memory with one registered read
// port, and a pixel's results leave through the output register. The input
// takes one request per cycle while each pixel yields at most one result and
// the output is not stalled, and is held by a pixel with several results.
// The user writes display_mode only while the block is idle; it is not enforced.
module palette_line_scaler_unit import pls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  pls_req_if.sink          in_chan,
  pls_rsp_if.source        out_chan
);

  logic [ColorW-1:0] pal_mem [PaletteDepth];
  logic [ColorW-1:0] pal_rd_q;

  display_mode_e       mode_q;
  logic [SrcColW-1:0]  src_col_q, src_col_d;
  logic [OutColW-1:0]  next_col_q, next_col_d;
  logic [RunCntW-1:0]  run_cnt_q, run_cnt_d;

  logic                s1_valid_q, s1_valid_d;
  logic [SrcColW-1:0]  s1_src_q, s1_src_d;
  logic                s1_code_ok_q, s1_code_ok_d;

  logic                out_valid_q, out_valid_d;
  logic [OutColW-1:0]  out_col_q, out_col_d;
  logic [ColorW-1:0]   out_color_q, out_color_d;
  logic                out_last_q, out_last_d;

  logic                in_accept, pix_accept, wr_accept;
  logic                code_ok, idx_ok;
  logic [OutColW-1:0]  col_plus;
  logic                hit, next_hit, last, out_free, emit, s1_done;

  assign in_accept  = in_chan.valid && in_chan.ready;
  assign pix_accept = in_accept && (in_chan.op == OpPixel);
  assign wr_accept  = in_accept && (in_chan.op == OpPalWrite);
  assign code_ok    = {1'b0, in_chan.pixel_code} < (CodeW + 1)'(PaletteDepth);
  assign idx_ok     = {1'b0, in_chan.palette_index} < (CodeW + 1)'(PaletteDepth);

  // Palette memory: write on palette requests, read on pixel requests
  always_ff @(posedge clk_i) begin
    if (wr_accept && idx_ok) begin
      pal_mem[in_chan.palette_index[PalAddrW-1:0]] <= in_chan.palette_color;
    end
    if (pix_accept) begin
      pal_rd_q <= pal_mem[in_chan.pixel_code[PalAddrW-1:0]];
    end
  end

  // Match the next output column against the pending pixel's source column
  always_comb begin
    col_plus = next_col_q + OutColW'(1);
    hit      = s1_valid_q && ({1'b0, next_col_q} < LineOutW) &&
               (map_column(mode_q, next_col_q) == s1_src_q);
    next_hit = ({1'b0, next_col_q} + (OutColW + 1)'(1) < LineOutW) &&
               (map_column(mode_q, col_plus) == s1_src_q);
    last     = !next_hit || (run_cnt_q == '1);
    out_free = !out_valid_q || out_chan.ready;
    emit     = hit && out_free;
    s1_done  = s1_valid_q && (!hit || (emit && last));
  end

  assign in_chan.ready = !s1_valid_q || s1_done;

  // Next-state logic for line position, pending pixel and output register
  always_comb begin
    src_col_d    = src_col_q;
    next_col_d   = next_col_q;
    run_cnt_d    = run_cnt_q;
    s1_valid_d   = s1_valid_q;
    s1_src_d     = s1_src_q;
    s1_code_ok_d = s1_code_ok_q;
    out_valid_d  = out_valid_q;
    out_col_d    = out_col_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;

    // advance output column on each emitted pixel
    if (emit) begin
      next_col_d = col_plus;
      run_cnt_d  = run_cnt_q + RunCntW'(1);
    end
    // retire the pending pixel; wrap the line after the last source column
    if (s1_done) begin
      s1_valid_d = 1'b0;
      run_cnt_d  = '0;
      if (s1_src_q == LastSrcCol) begin
        next_col_d = '0;
      end
    end
    // take a new pixel request
    if (pix_accept) begin
      s1_valid_d   = 1'b1;
      s1_src_d     = src_col_q;
      s1_code_ok_d = code_ok;
      src_col_d    = (src_col_q == LastSrcCol) ? '0 : src_col_q + SrcColW'(1);
    end

    // load or drop the output register
    if (emit) begin
      out_valid_d = 1'b1;
      out_col_d   = next_col_q;
      out_color_d = (is_bar(mode_q, next_col_q) || !s1_code_ok_q) ? Black : pal_rd_q;
      out_last_d  = last;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeStretch;
      src_col_q   <= '0;
      next_col_q  <= '0;
      run_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= display_mode_e'(cfg_wdata_i);
      end
      src_col_q   <= src_col_d;
      next_col_q  <= next_col_d;
      run_cnt_q   <= run_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_src_q     <= s1_src_d;
    s1_code_ok_q <= s1_code_ok_d;
    out_col_q    <= out_col_d;
    out_color_q  <= out_color_d;
    out_last_q   <= out_last_d;
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.out_column  = out_col_q;
  assign out_chan.pixel_color = out_color_q;
  assign out_chan.last_of_run = out_last_q;

endmodule

FILE: dv/palette_line_scaler_unit_tb.sv
`timescale 1ns / 1ps

module palette_line_scaler_unit_tb;
  import pls_pkg::*;

  typedef struct packed {
    op_e               op;
    logic [CodeW-1:0]  pixel_code;
    logic [CodeW-1:0]  palette_index;
    logic [ColorW-1:0] palette_color;
  } line_req_t;

  typedef struct {
    logic [OutColW-1:0] column;
    logic [ColorW-1:0]  color;
    logic               last;
  } out_pixel_t;

  typedef enum logic {RowRequest, RowMode} row_kind_e;

  // One opening row; a negative fixed_count leaves the expectation to the predictor
  typedef struct packed {
    row_kind_e         kind;
    display_mode_e     mode;
    line_req_t         req;
    int                fixed_count;
    int                fixed_col0;
    logic [ColorW-1:0] fixed_color;
  } opening_row_t;

  // One stretch of the line under a single display mode
  typedef struct packed {
    display_mode_e mode;
    int            stop_col;
  } line_leg_t;

  localparam int NoFixed    = -1;
  localparam int DrainCycles = 4;
  localparam int MaxPrints  = 40;
  localparam int MaxPerPixel = 8;

  localparam opening_row_t OpeningRows [16] = '{
    '{RowMode,    ModePillar,  '{OpPixel,    8'h00, 8'h00, 16'h0000}, 0, 0, Black},
    '{RowRequest, ModePillar,  '{OpPalWrite, 8'hFF, 8'h00, 16'h0000}, 0, 0, Black},
    '{RowRequest, ModePillar,  '{OpPalWrite, 8'h00, 8'hFF, 16'hFFFF}, 0, 0, Black},
    '{RowRequest, ModePillar,  '{OpPalWrite, 8'h3C, 8'hA5, 16'h5A5A}, 0, 0, Black},
    '{RowRequest, ModePillar,  '{OpPalWrite, 8'hC3, 8'h5A, 16'hA5A5}, 0, 0, Black},
    '{RowRequest, ModePillar,  '{OpPalWrite, 8'h80, 8'h01, 16'h8001}, 0, 0, Black},
    // left bar: seven black pixels at source column 0, palette ignored
    '{RowRequest, ModePillar,  '{OpPixel,    8'hFF, 8'h00, 16'h0000}, 7, 0, Black},
    '{RowRequest, ModePillar,  '{OpPixel,    8'h00, 8'hFF, 16'hFFFF}, 0, 0, Black},
    // palette load in mid-line leaves the position alone
    '{RowRequest, ModePillar,  '{OpPalWrite, 8'h80, 8'h7F, 16'h7FFF}, 0, 0, Black},
    '{RowRequest, ModePillar,  '{OpPixel,    8'hA5, 8'h5A, 16'hA5A5}, 0, 0, Black},
    '{RowMode,    ModeCover,   '{OpPixel,    8'h00, 8'h00, 16'h0000}, 0, 0, Black},
    '{RowRequest, ModeCover,   '{OpPixel,    8'h01, 8'hFF, 16'hFFFF}, NoFixed, 0, Black},
    '{RowRequest, ModeCover,   '{OpPixel,    8'h5A, 8'h00, 16'h0000}, NoFixed, 0, Black},
    '{RowRequest, ModeCover,   '{OpPixel,    8'h7F, 8'h80, 16'h8000}, NoFixed, 0, Black},
    '{RowRequest, ModeCover,   '{OpPixel,    8'h00, 8'h7F, 16'h7FFF}, NoFixed, 0, Black},
    '{RowRequest, ModeCover,   '{OpPixel,    8'hFF, 8'h01, 16'h0001}, NoFixed, 0, Black}
  };

  // Each switch lands where the output column still lies ahead, so the first line
  // runs through in full; the pillarbox leg crosses the line end for the right bar.
  // On the next line crop leaves pillarbox behind, stranding the rest of that line.
  localparam line_leg_t LineLegs [6] = '{
    '{ModeStretch, 100},
    '{ModeCrop,    220},
    '{ModeCover,   290},
    '{ModePillar,  0},
    '{ModeCrop,    76},
    '{ModePillar,  86}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic       take_pixel = 1'b0;

  pls_req_if req_chan ();
  pls_rsp_if rsp_chan ();

  assign rsp_chan.ready = take_pixel;

  palette_line_scaler_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_chan     (req_chan),
    .out_chan    (rsp_chan)
  );

  // Scaler state as the line is walked
  logic [ColorW-1:0] shade_table [PaletteDepth];
  bit                shade_loaded [PaletteDepth];
  logic [CodeW-1:0]  loaded_codes [$];
  display_mode_e     mode_now = ModeStretch;
  int                src_col = 0;
  int                next_col = 0;
  out_pixel_t        step_out [$];
  out_pixel_t        pixels_due [$];

  int src_idle_pct = 27;
  int sink_idle_pct = 74;
  int requests_sent = 0;
  int palette_writes = 0;
  int pixels_checked = 0;
  int line_wraps = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < MaxPrints) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Source column that feeds output column x; bar set for black pillarbox pixels
  function automatic int source_of(display_mode_e m, int x, output bit bar);
    int s;
    bar = 1'b0;
    if (m == ModeCrop) begin
      return CropStart + x;
    end
    if (m == ModePillar) begin
      if (x < LeftBar) begin
        bar = 1'b1;
        return 0;
      end
      if (x >= RightBarStart) begin
        bar = 1'b1;
        return LineIn - 1;
      end
      s = ((x - LeftBar) * ActiveW + InnerW / 2) / InnerW;
      if (s > ActiveW - 1) begin
        s = ActiveW - 1;
      end
      return ActiveStart + s;
    end
    return ActiveStart + (x * 4 + 1) / 3;
  endfunction

  // Apply one request to the scaler state; output pixels land in step_out
  function automatic void advance_line(line_req_t r);
    logic [ColorW-1:0] shade;
    bit                bar;
    out_pixel_t        px;
    step_out.delete();
    if (r.op == OpPalWrite) begin
      if (int'(r.palette_index) < PaletteDepth) begin
        if (!shade_loaded[r.palette_index]) begin
          loaded_codes.push_back(r.palette_index);
        end
        shade_loaded[r.palette_index] = 1'b1;
        shade_table[r.palette_index] = r.palette_color;
      end
      return;
    end
    shade = (int'(r.pixel_code) < PaletteDepth) ? shade_table[r.pixel_code] : Black;
    // emit every output column mapped to this source column, in order
    while (step_out.size() < MaxPerPixel && next_col < LineOut) begin
      if (source_of(mode_now, next_col, bar) != src_col) begin
        break;
      end
      px.column = OutColW'(next_col);
      px.color = bar ? Black : shade;
      px.last = 1'b0;
      step_out.push_back(px);
      next_col++;
    end
    if (step_out.size() > 0) begin
      step_out[step_out.size() - 1].last = 1'b1;
    end
    // advance the source position, wrap at end of line
    src_col++;
    if (src_col >= LineIn) begin
      src_col = 0;
      next_col = 0;
      line_wraps++;
    end
  endfunction

  task automatic send_request(line_req_t r, int fixed_count = NoFixed, int fixed_col0 = 0,
                              logic [ColorW-1:0] fixed_color = Black);
    out_pixel_t px;
    // pick the idle pattern from how far the run has come
    if (requests_sent < 170) begin
      src_idle_pct = 27;
      sink_idle_pct = 74;
    end else if (requests_sent < 340) begin
      src_idle_pct = 74;
      sink_idle_pct = 27;
    end else begin
      src_idle_pct = 0;
      sink_idle_pct = 0;
    end
    req_chan.valid <= 1'b1;
    req_chan.op <= r.op;
    req_chan.pixel_code <= r.pixel_code;
    req_chan.palette_index <= r.palette_index;
    req_chan.palette_color <= r.palette_color;
    do @(posedge clk); while (req_chan.ready !== 1'b1);
    // request accepted: queue its output pixels
    advance_line(r);
    requests_sent++;
    if (r.op == OpPalWrite) begin
      palette_writes++;
    end
    if (fixed_count < 0) begin
      foreach (step_out[i]) begin
        pixels_due.push_back(step_out[i]);
      end
    end else begin
      for (int i = 0; i < fixed_count; i++) begin
        px.column = OutColW'(fixed_col0 + i);
        px.color = fixed_color;
        px.last = (i == fixed_count - 1);
        pixels_due.push_back(px);
      end
    end
    // hold off the next request now and then
    if ($urandom_range(99) < src_idle_pct) begin
      req_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // Write the mode only once the block has gone quiet
  task automatic set_display_mode(display_mode_e m);
    req_chan.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_wdata <= m;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_now = m;
  endtask

  // Check each output pixel against the oldest pending one; stall at random
  always @(posedge clk) begin : pixel_monitor
    out_pixel_t want;
    if (rsp_chan.valid === 1'b1 && take_pixel === 1'b1) begin
      pixels_checked++;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("column %0d color %h with no pixel pending",
                                  rsp_chan.out_column, rsp_chan.pixel_color));
      end else begin
        want = pixels_due.pop_front();
        if (rsp_chan.out_column !== want.column) begin
          report_mismatch($sformatf("out_column got %0d want %0d",
                                    rsp_chan.out_column, want.column));
        end
        if (rsp_chan.pixel_color !== want.color) begin
          report_mismatch($sformatf("pixel_color got %h want %h at column %0d",
                                    rsp_chan.pixel_color, want.color, want.column));
        end
        if (rsp_chan.last_of_run !== want.last) begin
          report_mismatch($sformatf("last_of_run got %b want %b at column %0d",
                                    rsp_chan.last_of_run, want.last, want.column));
        end
      end
    end
    take_pixel <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    line_req_t r;
    req_chan.valid <= 1'b0;
    req_chan.op <= OpPixel;
    req_chan.pixel_code <= '0;
    req_chan.palette_index <= '0;
    req_chan.palette_color <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= ModeStretch;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // opening rows: palette loads, bars, ignored fields
    foreach (OpeningRows[i]) begin
      if (OpeningRows[i].kind == RowMode) begin
        set_display_mode(OpeningRows[i].mode);
      end else begin
        send_request(OpeningRows[i].req, OpeningRows[i].fixed_count,
                     OpeningRows[i].fixed_col0, OpeningRows[i].fixed_color);
      end
    end

    // random legs: mostly pixels from loaded entries, some palette loads
    foreach (LineLegs[k]) begin
      set_display_mode(LineLegs[k].mode);
      do begin
        r.pixel_code = CodeW'($urandom);
        r.palette_index = CodeW'($urandom);
        r.palette_color = ColorW'($urandom);
        if ($urandom_range(99) < 8) begin
          r.op = OpPalWrite;
        end else begin
          r.op = OpPixel;
          r.pixel_code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
        end
        send_request(r);
      end while (src_col != LineLegs[k].stop_col);
    end
    req_chan.valid <= 1'b0;

    // drain, then watch for stray pixels
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DrainCycles * 4) @(posedge clk);

    $display("run: %0d requests (%0d palette loads), %0d output pixels checked",
             requests_sent, palette_writes, pixels_checked);
    $display("run: all four display modes, %0d line wrap(s), bars and mid-line switches",
             line_wraps);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: 5 ms, far beyond the slowest stall pattern
  initial begin
    #5_000_000;
    $display("timeout with %0d pixels still pending", pixels_due.size());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hdl/pls_pkg.sv
hdl/pls_req_if.sv
hdl/pls_rsp_if.sv
hdl/palette_line_scaler_unit.sv
dv/palette_line_scaler_unit_tb.sv
